/* rtl/pid_controller_with_limits_top_macros.svh */
// Assertion macros used by the checker in rtl/pidcl_checker.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef PID_CONTROLLER_WITH_LIMITS_TOP_MACROS_SVH
`define PID_CONTROLLER_WITH_LIMITS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIDCL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pidcl_pkg.sv */
`timescale 1ns / 1ps

package pidcl_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_W     = 66;

   localparam logic signed [31:0] DERIV_UPPER_LIMIT = 32'sd0;
   localparam logic signed [31:0] DERIV_LOWER_LIMIT = 32'sd0;

   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 31;
   localparam int DIV_CNT_W = 6;

   localparam logic signed [WIDE_W-1:0] SAT_MAX =
      signed'((WIDE_W)'(1) << (SAT_BITS - 1)) - (WIDE_W)'(1);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - (WIDE_W)'(1);

   typedef enum logic [2:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_SAMPLE_PERIOD   = 3'd3,
      CSR_INTEG_IN_UPPER  = 3'd4,
      CSR_INTEG_IN_LOWER  = 3'd5,
      CSR_INTEG_OUT_UPPER = 3'd6,
      CSR_INTEG_OUT_LOWER = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      CTRL_IDLE,
      CTRL_INT_MUL,
      CTRL_INT_ADD,
      CTRL_P_ACC,
      CTRL_I_ACC,
      CTRL_D_WAIT,
      CTRL_D_MUL,
      CTRL_D_ACC,
      CTRL_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIX
   } div_state_type;

   function automatic logic signed [31:0] sat_wide(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      r = v;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[31:0];
   endfunction

endpackage

/* rtl/pidcl_div.sv */
`timescale 1ns / 1ps

module pidcl_div import pidcl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_NUM_W-1:0] numer,
   input  logic        [DIV_DEN_W-1:0] denom,
   output logic                        done,
   output logic signed [31:0]          quot
);

   div_state_type                state_ff, state_in;
   logic [DIV_CNT_W-1:0]         count_ff, count_in;
   logic                         neg_ff, neg_in;
   logic [DIV_DEN_W-1:0]         den_ff, den_in;
   logic [DIV_DEN_W-1:0]         rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]         quo_ff, quo_in;
   logic signed [31:0]           res_ff, res_in;

   logic [DIV_DEN_W:0]           trial;
   logic [DIV_DEN_W:0]           trial_diff;
   logic                         fits;
   logic signed [DIV_NUM_W:0]    mag;
   logic signed [DIV_NUM_W:0]    floored;

   assign trial      = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = trial >= {1'b0, den_ff};
   assign mag        = signed'({1'b0, quo_ff});
   // A negative quotient with a nonzero remainder rounds one further down.
   assign floored    = neg_ff ? (~mag + (DIV_NUM_W + 1)'(rem_ff == '0)) : mag;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in   = numer[DIV_NUM_W-1];
               quo_in   = numer[DIV_NUM_W-1] ? unsigned'(-numer) : unsigned'(numer);
               rem_in   = '0;
               den_in   = denom;
               count_in = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in   = fits ? trial_diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_in   = {quo_ff[DIV_NUM_W-2:0], fits};
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               state_in = DIV_FIX;
            end
         end
         DIV_FIX: begin
            res_in   = sat_wide(WIDE_W'(floored));
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      res_ff   <= res_in;
   end

   assign done = (state_ff == DIV_IDLE);
   assign quot = res_ff;

endmodule

/* rtl/pid_controller_with_limits_top.sv */
`timescale 1ns / 1ps

// PID controller with integral window and clamp. Each request beat carries one signed
// Q16.16 error sample and produces one saturated Q16.16 drive value on the response
// channel. The 49-step serial divider forms the derivative, while a single shared
// 32x32 multiplier forms the integral increment and the three gain products in turn.
// The block takes one item at a time and accepts the next one while the previous
// response still waits to be taken. The user must write the configuration registers
// through the csr port only while the block is idle; the block does not enforce this.
// A zero limit disables that limit.
module pid_controller_with_limits_top import pidcl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_error_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_value,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   logic signed [31:0]    gain_p_ff, gain_i_ff, gain_d_ff;
   logic [DIV_DEN_W-1:0]  period_ff;
   logic signed [31:0]    in_upper_ff, in_lower_ff, out_upper_ff, out_lower_ff;

   ctrl_state_type        state_ff, state_in;
   logic signed [31:0]    sample_ff, sample_in;
   logic signed [31:0]    prev_ff, prev_in;
   logic signed [31:0]    integ_ff, integ_in;
   logic signed [31:0]    deriv_ff, deriv_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic signed [WIDE_W-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_data_ff, rsp_data_in;

   logic signed [31:0]    mul_a, mul_b;
   logic                  div_start, div_done;
   logic signed [31:0]    div_quot;
   logic [DIV_DEN_W-1:0]  dt_eff;
   logic signed [32:0]    diff;
   logic signed [DIV_NUM_W-1:0] div_numer;

   logic signed [63:0]    prod_shift;
   logic signed [WIDE_W-1:0] int_sum;
   logic                  skip;
   logic signed [31:0]    int_upd, int_hi, integ_next;
   logic                  deriv_out;
   logic signed [31:0]    deriv_sel;

   assign dt_eff    = (period_ff == '0) ? DIV_DEN_W'(1) : period_ff;
   assign diff      = 33'(req_error_sample) - 33'(prev_ff);
   assign div_numer = {diff, {FRAC_BITS{1'b0}}};

   pidcl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (dt_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign prod_in    = mul_a * mul_b;
   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign int_sum    = WIDE_W'(integ_ff) + WIDE_W'(prod_shift);
   assign skip       = ((in_lower_ff != '0) && (sample_ff < in_lower_ff)) ||
                       ((in_upper_ff != '0) && (sample_ff > in_upper_ff));
   assign int_upd    = skip ? integ_ff : sat_wide(int_sum);
   assign int_hi     = ((out_upper_ff != '0) && (int_upd > out_upper_ff)) ? out_upper_ff
                                                                          : int_upd;
   assign integ_next = ((out_lower_ff != '0) && (int_hi < out_lower_ff)) ? out_lower_ff
                                                                         : int_hi;

   assign deriv_out  = ((DERIV_UPPER_LIMIT != '0) && (div_quot > DERIV_UPPER_LIMIT)) ||
                       ((DERIV_LOWER_LIMIT != '0) && (div_quot < DERIV_LOWER_LIMIT));
   assign deriv_sel  = ((gain_d_ff == '0) || deriv_out) ? '0 : div_quot;

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = sample_ff;
      mul_b        = gain_p_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               sample_in = req_error_sample;
               prev_in   = req_error_sample;
               div_start = 1'b1;
               state_in  = CTRL_INT_MUL;
            end
         end
         CTRL_INT_MUL: begin
            mul_b    = signed'({1'b0, dt_eff});
            state_in = CTRL_INT_ADD;
         end
         CTRL_INT_ADD: begin
            integ_in = integ_next;
            state_in = CTRL_P_ACC;
         end
         CTRL_P_ACC: begin
            acc_in   = WIDE_W'(prod_ff);
            mul_a    = integ_ff;
            mul_b    = gain_i_ff;
            state_in = CTRL_I_ACC;
         end
         CTRL_I_ACC: begin
            acc_in   = acc_ff + WIDE_W'(prod_ff);
            state_in = CTRL_D_WAIT;
         end
         CTRL_D_WAIT: begin
            if (div_done) begin
               deriv_in = deriv_sel;
               state_in = CTRL_D_MUL;
            end
         end
         CTRL_D_MUL: begin
            mul_a    = deriv_ff;
            mul_b    = gain_d_ff;
            state_in = CTRL_D_ACC;
         end
         CTRL_D_ACC: begin
            acc_in   = acc_ff + WIDE_W'(prod_ff);
            state_in = CTRL_OUT;
         end
         CTRL_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_wide(acc_ff >>> FRAC_BITS);
               state_in     = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
      end
      sample_ff   <= sample_in;
      deriv_ff    <= deriv_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 32'sd65536;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         period_ff    <= DIV_DEN_W'(65536);
         in_upper_ff  <= '0;
         in_lower_ff  <= '0;
         out_upper_ff <= '0;
         out_lower_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:          gain_p_ff    <= signed'(csr_wr_data);
            CSR_GAIN_I:          gain_i_ff    <= signed'(csr_wr_data);
            CSR_GAIN_D:          gain_d_ff    <= signed'(csr_wr_data);
            CSR_SAMPLE_PERIOD:   period_ff    <= csr_wr_data[DIV_DEN_W-1:0];
            CSR_INTEG_IN_UPPER:  in_upper_ff  <= signed'(csr_wr_data);
            CSR_INTEG_IN_LOWER:  in_lower_ff  <= signed'(csr_wr_data);
            CSR_INTEG_OUT_UPPER: out_upper_ff <= signed'(csr_wr_data);
            CSR_INTEG_OUT_LOWER: out_lower_ff <= signed'(csr_wr_data);
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_data_ff;

endmodule

/* rtl/pidcl_checker.sv */
`timescale 1ns / 1ps
`include "pid_controller_with_limits_top_macros.svh"

module pidcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_drive_value
);

   `PIDCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive_value), "Response beat changed while stalled.")
   `PIDCL_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready, "Request taken while an item is still in progress.")
   `PIDCL_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "Response appeared without an item in progress.")
   `PIDCL_ASSERT_NOW(a_after_reset, $past(reset), !rsp_valid && req_ready, "Block not idle after reset.")

endmodule

bind pid_controller_with_limits_top pidcl_checker u_pidcl_checker (.*);

/* tb/pid_controller_with_limits_checker.sv */
`timescale 1ns / 1ps

module pid_controller_with_limits_checker import pidcl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_error_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_drive_value,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data,
   output int                 fail_count,
   output int                 pending_count
);

   localparam longint CLIP_HI = 64'sd2147483647;
   localparam longint CLIP_LO = -64'sd2147483648;

   logic signed [31:0] kp, ki, kd;
   logic [30:0]        period;
   logic signed [31:0] win_upper, win_lower, clamp_upper, clamp_lower;
   logic signed [31:0] integ_acc, last_sample;
   logic signed [31:0] drive_queue [$];
   int                 drive_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      drive_seen    = 0;
   end

   function automatic logic signed [31:0] clip32(input logic signed [79:0] v);
      if (v > CLIP_HI) return 32'sh7fff_ffff;
      if (v < CLIP_LO) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if (n % d < 0) q = q - 1;
      return q;
   endfunction

   // Advances the integral and the sample history by one error sample and
   // returns the drive value that the block must produce for it.
   function automatic logic signed [31:0] step_loop(input logic signed [31:0] e);
      longint             ev, dt, rate, pterm, iterm, dterm;
      logic signed [79:0] total;
      logic               outside;
      ev = e;
      dt = (period == 31'd0) ? 64'sd1 : longint'(period);
      rate = 0;
      if (kd != 0) begin
         rate = clip32(floor_div((ev - last_sample) * 65536, dt));
         if ((DERIV_UPPER_LIMIT != 0 && rate > DERIV_UPPER_LIMIT) ||
             (DERIV_LOWER_LIMIT != 0 && rate < DERIV_LOWER_LIMIT)) rate = 0;
      end
      outside = (win_lower != 0 && e < win_lower) || (win_upper != 0 && e > win_upper);
      if (!outside) integ_acc = clip32(longint'(integ_acc) + ((ev * dt) >>> 16));
      if (clamp_upper != 0 && integ_acc > clamp_upper) integ_acc = clamp_upper;
      if (clamp_lower != 0 && integ_acc < clamp_lower) integ_acc = clamp_lower;
      pterm = longint'(kp) * ev;
      iterm = longint'(ki) * longint'(integ_acc);
      dterm = longint'(kd) * rate;
      total = pterm;
      total = total + iterm + dterm;
      last_sample = e;
      return clip32(total >>> 16);
   endfunction

   task automatic note_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         kp          = 32'sh0001_0000;
         ki          = '0;
         kd          = '0;
         period      = 31'h0001_0000;
         win_upper   = '0;
         win_lower   = '0;
         clamp_upper = '0;
         clamp_lower = '0;
         integ_acc   = '0;
         last_sample = '0;
         drive_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_P:          kp = csr_wr_data;
               CSR_GAIN_I:          ki = csr_wr_data;
               CSR_GAIN_D:          kd = csr_wr_data;
               CSR_SAMPLE_PERIOD:   period = csr_wr_data[30:0];
               CSR_INTEG_IN_UPPER:  win_upper = csr_wr_data;
               CSR_INTEG_IN_LOWER:  win_lower = csr_wr_data;
               CSR_INTEG_OUT_UPPER: clamp_upper = csr_wr_data;
               CSR_INTEG_OUT_LOWER: clamp_lower = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            drive_seen++;
            if (drive_queue.size() == 0) begin
               note_mismatch($sformatf("drive_value %0d on beat %0d with nothing outstanding",
                                       rsp_drive_value, drive_seen));
            end else begin
               want = drive_queue.pop_front();
               if (rsp_drive_value !== want) begin
                  note_mismatch($sformatf("drive_value mismatch on beat %0d: got %0d, wanted %0d",
                                          drive_seen, rsp_drive_value, want));
               end
            end
         end
         if (req_valid && req_ready) drive_queue.push_back(step_loop(req_error_sample));
      end
      pending_count = drive_queue.size();
   end

endmodule

/* tb/pid_controller_with_limits_top_tb.sv */
`timescale 1ns / 1ps

module pid_controller_with_limits_top_tb;
   import pidcl_pkg::*;

   typedef logic [31:0] csr_image_t [8];

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_error_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic signed [31:0] rsp_drive_value;
   logic               csr_wr_en        = 1'b0;
   logic [2:0]         csr_index        = '0;
   logic [31:0]        csr_wr_data      = '0;
   int                 fail_count;
   int                 pending_count;

   logic               quiet     = 1'b0;
   logic               rsp_taken = 1'b0;
   int                 rsp_hold  = 0;
   logic signed [31:0] last_sent = '0;

   pid_controller_with_limits_top dut (.*);

   pid_controller_with_limits_checker drive_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function int idle_draw();
      return quiet ? 0 : int'($urandom_range(0, 14));
   endfunction

   always @(posedge clock) rsp_taken <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_taken) rsp_hold = idle_draw();
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      endcase
   endfunction

   function logic [31:0] pick_period();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'h0000_0001;
         2: return 32'h7fff_ffff;
         3: return 32'h0001_0000;
         4: return $urandom;
         default: return $urandom_range(1, 32'h4_0000);
      endcase
   endfunction

   function logic [31:0] pick_limit(input logic upper_side);
      case ($urandom_range(0, 7))
         0, 1, 2: return '0;
         3: return $urandom;
         4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return upper_side ? $urandom_range(1, 32'h8_0000)
                                    : 32'h0 - $urandom_range(1, 32'h8_0000);
      endcase
   endfunction

   function logic signed [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return '0;
               default: return -32'sd1;
            endcase
         end
         2: return last_sent;
         default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
   endfunction

   function csr_image_t random_image();
      csr_image_t img;
      img[CSR_GAIN_P]          = pick_gain();
      img[CSR_GAIN_I]          = pick_gain();
      img[CSR_GAIN_D]          = pick_gain();
      img[CSR_SAMPLE_PERIOD]   = pick_period();
      img[CSR_INTEG_IN_UPPER]  = pick_limit(1'b1);
      img[CSR_INTEG_IN_LOWER]  = pick_limit(1'b0);
      img[CSR_INTEG_OUT_UPPER] = pick_limit(1'b1);
      img[CSR_INTEG_OUT_LOWER] = pick_limit(1'b0);
      return img;
   endfunction

   task automatic send_sample(input logic signed [31:0] e);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_error_sample <= e;
      last_sent = e;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Holds the sender off until every drive value has been taken, then lets
   // the block settle before anything else happens.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   task automatic program_csrs(input csr_image_t image);
      for (int k = 0; k < 8; k++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= 3'(k);
         csr_wr_data <= image[k];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      csr_image_t image;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_sample(32'sh0000_0000);
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh8000_0000);
      send_sample(32'shffff_ffff);
      send_sample(32'sh0000_0001);

      // Full-scale gains with a zero sample period.
      wait_drained();
      image = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000,
                32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      program_csrs(image);
      quiet = 1'b1;
      send_sample(32'sh8000_0000);
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh8000_0000);
      send_sample(32'shffff_0001);

      // Input window active and the output limits crossed.
      wait_drained();
      image = '{32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                32'h0005_0000, 32'hfffb_0000, 32'h0001_0000, 32'h0002_0000};
      program_csrs(image);
      quiet = 1'b0;
      send_sample(32'sh0003_0000);
      send_sample(32'sh0006_0000);
      send_sample(32'shfff0_0000);
      send_sample(32'shffff_8000);
      send_sample(32'sh0000_0001);

      // Every limit at its extreme and the smallest sample period.
      wait_drained();
      image = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      program_csrs(image);
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh8000_0000);
      send_sample(32'sh1234_5678);
      send_sample(32'shedcb_a988);

      for (int phase = 0; phase < 10; phase++) begin
         wait_drained();
         image = random_image();
         program_csrs(image);
         repeat (150) begin
            if ($urandom_range(0, 39) == 0) quiet = ~quiet;
            if ($urandom_range(0, 59) == 0) wait_drained();
            send_sample(pick_sample());
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/pidcl_pkg.sv
rtl/pidcl_div.sv
rtl/pid_controller_with_limits_top.sv
rtl/pidcl_checker.sv
tb/pid_controller_with_limits_checker.sv
tb/pid_controller_with_limits_top_tb.sv
